/* sv/rpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the relation property checker
// Beat layouts, operation codes, decoded commands and back-end states.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Field widths of the beats
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned ROW_BITS_W = 16;
  localparam int unsigned SIZE_W     = 5;

  // Configuration port
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;
  localparam logic        REG_SIZE   = 1'b0;   // register index, paddr[2]
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Command queue depth between front and back
  localparam int unsigned CMD_DEPTH  = 2;

  // Operation codes of the input beat
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] left_element;
    logic [ELEM_W-1:0] right_element;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  is_reflexive;
    logic                  is_symmetric;
    logic                  is_antisymmetric;
    logic                  is_transitive;
    logic                  is_equivalence;
    logic                  is_partial_order;
    logic [ROW_BITS_W-1:0] row_bits;
  } out_item_t;

  // Decoded command; rejected inserts, rejected reads and unknown codes
  // all collapse to CMD_REJECT.
  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_CLEAR,
    CMD_QUERY,
    CMD_CLOSE,
    CMD_READ,
    CMD_REJECT
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [ELEM_W-1:0] row;   // element minus one
    logic [ELEM_W-1:0] col;   // element minus one
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_EX,
    BK_OUT
  } bk_state_e;

endpackage

/* sv/rpc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_front: input classifier
// Range-check the elements of each beat and turn it into a command.
// ----------------------------------------------------------------------------
module rpc_front #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  rpc_pkg::in_item_t                    in_data_i,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    eff_size_i,
  output rpc_pkg::cmd_t                        cmd_o
);

  logic [rpc_pkg::ELEM_W-1:0] size_ext;
  logic                       left_ok;
  logic                       right_ok;

  assign size_ext = rpc_pkg::ELEM_W'(eff_size_i);
  assign left_ok  = (in_data_i.left_element != '0) && (in_data_i.left_element <= size_ext);
  assign right_ok = (in_data_i.right_element != '0) && (in_data_i.right_element <= size_ext);

  always_comb begin
    cmd_o.row = in_data_i.left_element - rpc_pkg::ELEM_W'(1);
    cmd_o.col = in_data_i.right_element - rpc_pkg::ELEM_W'(1);
    case (in_data_i.op)
      rpc_pkg::OP_INSERT: begin
        cmd_o.kind = (left_ok && right_ok) ? rpc_pkg::CMD_INSERT : rpc_pkg::CMD_REJECT;
      end
      rpc_pkg::OP_CLEAR: begin
        cmd_o.kind = rpc_pkg::CMD_CLEAR;
      end
      rpc_pkg::OP_QUERY: begin
        cmd_o.kind = rpc_pkg::CMD_QUERY;
      end
      rpc_pkg::OP_CLOSE: begin
        cmd_o.kind = rpc_pkg::CMD_CLOSE;
      end
      rpc_pkg::OP_READ: begin
        cmd_o.kind = left_ok ? rpc_pkg::CMD_READ : rpc_pkg::CMD_REJECT;
      end
      default: begin
        cmd_o.kind = rpc_pkg::CMD_REJECT;
      end
    endcase
  end

endmodule

/* sv/rpc_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cmd_fifo: command queue
// Short queue that lets the classifier and the executor stall on their own.
// ----------------------------------------------------------------------------
module rpc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rpc_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rpc_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned Depth = rpc_pkg::CMD_DEPTH;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam logic [PW-1:0] PtrLast = PW'(Depth - 1);

  rpc_pkg::cmd_t   entry_q [Depth];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(Depth)) && !(push_i && full_o) && !(pop_i && empty_o))
    else $error("command queue over- or underflow");

endmodule

/* sv/rpc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_back: relation executor
// Hold the relation matrix and carry out one command at a time on it.
// ----------------------------------------------------------------------------
module rpc_back #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0] eff_size_i,
  input  logic                              cmd_empty_i,
  input  rpc_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rpc_pkg::out_item_t                out_data_o
);

  localparam int unsigned N   = MAX_ELEMENTS;
  localparam int unsigned IW  = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned SW  = $clog2(N + 1);
  localparam int unsigned RBW = (N < rpc_pkg::ROW_BITS_W) ? N : rpc_pkg::ROW_BITS_W;
  localparam logic [IW-1:0] Last = IW'(N - 1);

  rpc_pkg::bk_state_e state_q, state_d;
  rpc_pkg::cmd_t      cmd_q;

  // Matrix rows; vld_q marks rows written since the last clear
  logic [N-1:0]  mem_q [N];
  logic [N-1:0]  vld_q;
  logic [N-1:0]  rd_a_q, rd_b_q;

  logic [IW-1:0] ci_q, cj_q;
  logic          refl_q, sym_q, anti_q, trans_q;
  logic          refl_d, sym_d, anti_d, trans_d;

  logic          last_pair;
  logic          out_free;
  logic          clr_all;
  logic          rd_en;
  logic          we;
  logic          step_adv;
  logic          out_load;
  logic [IW-1:0] addr_a, addr_b, waddr;
  logic [N-1:0]  wdata;
  logic [N-1:0]  col_bit;
  rpc_pkg::out_item_t res;
  rpc_pkg::out_item_t out_q;
  logic          out_valid_q;

  assign last_pair = (ci_q == Last) && (cj_q == Last);
  assign out_free  = !out_valid_q || out_ready_i;
  assign col_bit   = N'(1) << cmd_q.col[IW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpc_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.kind == rpc_pkg::CMD_CLEAR || cmd_i.kind == rpc_pkg::CMD_REJECT) begin
            state_d = rpc_pkg::BK_OUT;
          end else begin
            state_d = rpc_pkg::BK_RD;
          end
        end
      end
      rpc_pkg::BK_RD: begin
        state_d = rpc_pkg::BK_EX;
      end
      rpc_pkg::BK_EX: begin
        if ((cmd_q.kind == rpc_pkg::CMD_QUERY || cmd_q.kind == rpc_pkg::CMD_CLOSE)
            && !last_pair) begin
          state_d = rpc_pkg::BK_RD;
        end else begin
          state_d = rpc_pkg::BK_OUT;
        end
      end
      rpc_pkg::BK_OUT: begin
        if (out_free) begin
          state_d = rpc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rpc_pkg::BK_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop_o = (state_q == rpc_pkg::BK_IDLE) && !cmd_empty_i;
    clr_all   = cmd_pop_o && (cmd_i.kind == rpc_pkg::CMD_CLEAR);
    rd_en     = (state_q == rpc_pkg::BK_RD);
    step_adv  = (state_q == rpc_pkg::BK_EX);
    out_load  = (state_q == rpc_pkg::BK_OUT) && out_free;
    we        = 1'b0;
    waddr     = cj_q;
    wdata     = rd_a_q | rd_b_q;
    case (cmd_q.kind)
      rpc_pkg::CMD_QUERY: begin
        addr_a = ci_q;
        addr_b = cj_q;
      end
      rpc_pkg::CMD_CLOSE: begin
        addr_a = cj_q;
        addr_b = ci_q;
        we     = step_adv && rd_a_q[ci_q];
      end
      rpc_pkg::CMD_INSERT: begin
        addr_a = cmd_q.row[IW-1:0];
        addr_b = ci_q;
        we     = step_adv;
        waddr  = cmd_q.row[IW-1:0];
        wdata  = rd_a_q | col_bit;
      end
      default: begin
        addr_a = cmd_q.row[IW-1:0];
        addr_b = ci_q;
      end
    endcase
  end

  // Query flags: rows i and j of the current pair sit in rd_a_q and rd_b_q
  always_comb begin
    refl_d  = refl_q;
    sym_d   = sym_q;
    anti_d  = anti_q;
    trans_d = trans_q;
    if (step_adv && cmd_q.kind == rpc_pkg::CMD_QUERY) begin
      if ((ci_q == cj_q) && (SW'(ci_q) < eff_size_i) && !rd_a_q[ci_q]) begin
        refl_d = 1'b0;
      end
      if (rd_a_q[cj_q]) begin
        if (!rd_b_q[ci_q]) begin
          sym_d = 1'b0;
        end else if (ci_q != cj_q) begin
          anti_d = 1'b0;
        end
        if ((rd_b_q & ~rd_a_q) != '0) begin
          trans_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res                  = '0;
    res.accepted         = (cmd_q.kind != rpc_pkg::CMD_REJECT);
    if (cmd_q.kind == rpc_pkg::CMD_QUERY) begin
      res.is_reflexive     = refl_q;
      res.is_symmetric     = sym_q;
      res.is_antisymmetric = anti_q;
      res.is_transitive    = trans_q;
      res.is_equivalence   = refl_q && sym_q && trans_q;
      res.is_partial_order = refl_q && anti_q && trans_q;
    end
    if (cmd_q.kind == rpc_pkg::CMD_READ) begin
      res.row_bits = rpc_pkg::ROW_BITS_W'(rd_a_q[RBW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpc_pkg::BK_IDLE;
      ci_q        <= '0;
      cj_q        <= '0;
      refl_q      <= 1'b1;
      sym_q       <= 1'b1;
      anti_q      <= 1'b1;
      trans_q     <= 1'b1;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        ci_q    <= '0;
        cj_q    <= '0;
        refl_q  <= 1'b1;
        sym_q   <= 1'b1;
        anti_q  <= 1'b1;
        trans_q <= 1'b1;
      end else begin
        refl_q  <= refl_d;
        sym_q   <= sym_d;
        anti_q  <= anti_d;
        trans_q <= trans_d;
        if (step_adv) begin
          if (cj_q == Last) begin
            cj_q <= '0;
            ci_q <= (ci_q == Last) ? '0 : ci_q + IW'(1);
          end else begin
            cj_q <= cj_q + IW'(1);
          end
        end
      end
      if (clr_all) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and the row memory
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a_q <= vld_q[addr_a] ? mem_q[addr_a] : '0;
      rd_b_q <= vld_q[addr_b] ? mem_q[addr_b] : '0;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_all |=> (vld_q == '0))
    else $error("clear left rows marked valid");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rpc_pkg::BK_OUT))
    else $error("result beat raised outside the output state");

  a_counters_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ci_q <= Last) && (cj_q <= Last))
    else $error("pair counter ran past the last row");

endmodule

/* sv/relation_property_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relation_property_checker_unit: binary relation store and property checker
// Bit-matrix relation with insert, clear, query, transitive closure and read.
// ----------------------------------------------------------------------------
// Each input beat is range-checked by the front end and dropped into a
// two-entry command queue, so the input keeps taking beats while the queue
// has room, also while the back end works and while a finished result waits
// in the output register. The back end runs one command at a time against a
// MAX_ELEMENTS-row matrix memory with two registered read ports and one
// write port; row valid bits make reset and clear take effect at once.
// Clear and rejected items go from idle straight to the output state; insert
// and read pass through the read and execute states first. Query and
// closure visit every row pair, each pair being read and then evaluated or
// written on the matrix memory. Results come out one per item in input
// order. size_in_use is written through the APB port at byte address 0 and
// is read back there; values above MAX_ELEMENTS act as MAX_ELEMENTS.
// ----------------------------------------------------------------------------
module relation_property_checker_unit #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rpc_pkg::in_item_t             in_data_i,
  // Result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpc_pkg::out_item_t            out_data_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpc_pkg::APB_AW-1:0]    paddr,
  input  logic [rpc_pkg::APB_DW-1:0]    pwdata,
  output logic [rpc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned SW = $clog2(MAX_ELEMENTS + 1);

  logic [rpc_pkg::SIZE_W-1:0] size_q;
  logic [SW-1:0]              eff_size;
  logic                       cfg_wr;

  rpc_pkg::cmd_t              front_cmd;
  rpc_pkg::cmd_t              queue_cmd;
  logic                       queue_full;
  logic                       queue_empty;
  logic                       queue_pop;
  logic                       in_take;

  // Configuration register: write on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rpc_pkg::REG_SIZE);
  assign prdata = (paddr[2] == rpc_pkg::REG_SIZE) ? rpc_pkg::APB_DW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= rpc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      size_q <= pwdata[rpc_pkg::SIZE_W-1:0];
    end
  end

  // Clamp the base set to the matrix size
  always_comb begin
    if (8'(size_q) > 8'(MAX_ELEMENTS)) begin
      eff_size = SW'(MAX_ELEMENTS);
    end else begin
      eff_size = SW'(size_q);
    end
  end

  // Front end: classify and enqueue
  assign in_ready_o = !queue_full;
  assign in_take    = in_valid_i && in_ready_o;

  rpc_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .in_data_i  (in_data_i),
    .eff_size_i (eff_size),
    .cmd_o      (front_cmd)
  );

  rpc_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_take),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_cmd),
    .empty_o     (queue_empty)
  );

  // Back end: execute against the matrix and drive the result beat
  rpc_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_size_i  (eff_size),
    .cmd_empty_i (queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_size_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (size_q == $past(pwdata[rpc_pkg::SIZE_W-1:0])))
    else $error("size register did not take the written value");

endmodule
